[design/bldc_pkg.sv]
// shared types and constants for the buffer length drift corrector
// no dependencies; imported by bldc_div and the top level
package bldc_pkg;

  // field widths
  localparam int LEN_W  = 11;
  localparam int ADJ_W  = 12;
  localparam int RATE_W = 18;
  localparam int ERR_W  = 16;
  localparam int FRAC_W = 19;
  localparam int PROD_W = 28;
  // magnitude of fraction plus error times length fits in this many bits
  localparam int NUM_W  = 27;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  localparam int unsigned BLDC_CAPACITY_DEFAULT = 1024;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = RATE_W'(48000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_ERROR  = CFG_IDX_W'(1);

  // input kinds
  localparam logic KIND_BUFFER = 1'b0;
  localparam logic KIND_START  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] buffer_length;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0]        corrected_length;
    logic signed [ADJ_W-1:0] sample_adjust;
    logic                    range_error;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

[design/bldc_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on bldc_pkg
module bldc_div import bldc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic [NUM_W-1:0]  quotient,
  output logic [RATE_W-1:0] remainder,
  output div_stat_t         stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  dvd;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [RATE_W:0]   shifted;
  logic [RATE_W+1:0] diff;
  logic              borrow;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem, dvd[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign borrow  = diff[RATE_W+1];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[NUM_W-2:0], ~borrow};
      rem <= borrow ? shifted[RATE_W-1:0] : diff[RATE_W-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

[design/buffer_length_drift_corrector_unit.sv]
// top level of the buffer length drift corrector
// depends on bldc_pkg and bldc_div
//
// One request per audio buffer. A buffer with a nonzero rate error goes from
// acceptance to result through a multiply, an add, a sign step, the
// iterations of the bit-serial divider, one per quotient bit, a step to see
// the divider finish and a finishing step, which registers the result and
// waits while the output is stalled. The next request is taken back in idle
// after the result is registered. With a zero rate error the finishing step
// follows acceptance directly, and a stream start request gives no result.
// in_stall is high while a request is in work; a finished result waits in
// the output register while the next request is accepted. The fraction is
// kept exactly as a signed remainder over the sample rate; a sample rate of
// zero divides by one.
module buffer_length_drift_corrector_unit import bldc_pkg::*; #(
  parameter int unsigned BUFFER_CAPACITY = BLDC_CAPACITY_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CW = 30;
  localparam logic signed [CW-1:0] CAP_S = CW'(BUFFER_CAPACITY);

  state_t state, state_next;

  logic [RATE_W-1:0]        sample_rate;
  logic signed [ERR_W-1:0]  rate_error;
  logic signed [FRAC_W-1:0] frac;

  logic [LEN_W-1:0]         len;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] num;
  logic                     neg;
  logic                     corr_on;

  logic                     in_accept;
  logic                     out_free;
  logic                     div_start;
  logic [NUM_W-1:0]         div_dividend;
  logic [RATE_W-1:0]        div_divisor;
  logic [NUM_W-1:0]         div_quot;
  logic [RATE_W-1:0]        div_rem;
  div_stat_t                div_stat;

  logic signed [CW-1:0]     q;
  logic signed [CW-1:0]     corr_full;
  logic signed [CW-1:0]     corr_clamp;
  logic                     clamped;
  logic signed [FRAC_W-1:0] frac_new;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RESET;
      rate_error  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate <= cfg_data[RATE_W-1:0];
        REG_RATE_ERROR:  rate_error  <= $signed(cfg_data[ERR_W-1:0]);
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.kind == KIND_BUFFER) begin
          state_next = (rate_error != '0) ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_ABS;
      ST_ABS: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // operand capture, product and signed sum
  always_ff @(posedge clk) begin
    if (in_accept) begin
      len     <= in_data.buffer_length;
      corr_on <= (rate_error != '0);
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(rate_error * $signed({1'b0, len}));
    end
    if (state == ST_ADD) begin
      num <= prod + PROD_W'(frac);
    end
    if (state == ST_ABS) begin
      neg <= num[PROD_W-1];
    end
  end

  // divider operands: magnitude of the sum over the effective sample rate
  assign div_dividend = num[PROD_W-1] ? NUM_W'(-num) : num[NUM_W-1:0];
  assign div_divisor  = (sample_rate == '0) ? RATE_W'(1) : sample_rate;

  bldc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // signed whole part, new fraction and clamp to capacity
  always_comb begin
    q         = '0;
    frac_new  = frac;
    if (corr_on) begin
      q        = neg ? -CW'(div_quot) : CW'(div_quot);
      frac_new = neg ? -FRAC_W'(div_rem) : FRAC_W'(div_rem);
    end
    corr_full  = CW'(len) - q;
    clamped    = 1'b0;
    corr_clamp = corr_full;
    if (corr_full < 0) begin
      corr_clamp = '0;
      clamped    = 1'b1;
    end else if (corr_full > CAP_S) begin
      corr_clamp = CAP_S;
      clamped    = 1'b1;
    end
  end

  // fraction register
  always_ff @(posedge clk) begin
    if (rst) begin
      frac <= '0;
    end else if (in_accept && in_data.kind == KIND_START) begin
      frac <= '0;
    end else if (state == ST_FIN && out_free) begin
      frac <= frac_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_data.corrected_length <= corr_clamp[LEN_W-1:0];
      out_data.sample_adjust    <= ADJ_W'(CW'(len) - corr_clamp);
      out_data.range_error      <= clamped;
    end
  end

`ifndef ASSERT_OFF
  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider done outside divide state");

  // divider is running whenever the sequencer waits without a done
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !div_stat.done) |-> div_stat.busy)
    else $error("sequencer waits on an idle divider");

  // a new result appears only from the finishing step
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside finishing step");
`endif

endmodule
